[rtl/core/tme_pkg.sv]
package tme_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;
   localparam int PAGE_W  = 20;
   localparam int FRAME_W = 20;
   localparam int ASID_W  = 6;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;
   localparam int CMD_W   = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_ASID_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_ASID = 1'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD       = 3'd0,
      CMD_INVALIDATE = 3'd1,
      CMD_CLEAN      = 3'd2,
      CMD_FLUSH_ALL  = 3'd3,
      CMD_FLUSH_ID   = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [PAGE_W-1:0]  virt_page;
      logic [FRAME_W-1:0] phys_frame;
      logic               write_enable;
      logic               global_flag;
      logic [ASID_W-1:0]  target_asid;
      logic [SLOT_W-1:0]  victim_slot;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot_used;
      logic [COUNT_W-1:0] match_count;
   } rsp_type;

   // classified work handed from front to back
   typedef struct packed {
      logic               known;
      cmd_type            cmd;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
      logic               dirty;
      logic               glob;
      logic [ASID_W-1:0]  id;
      logic [ASID_W-1:0]  target;
      logic [SLOT_W-1:0]  victim;
      logic               all_ids;
   } op_type;

endpackage

[rtl/core/tme_if.sv]
interface tme_req_if;
   logic               valid;
   logic               ready;
   tme_pkg::req_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tme_rsp_if;
   logic               valid;
   logic               ready;
   tme_pkg::rsp_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/tme_front.sv]
module tme_front (
   input  logic               clock,
   input  logic               reset,
   tme_req_if.sink            req,
   input  logic               asid_mode,
   input  logic [tme_pkg::ASID_W-1:0] current_asid,
   output logic               op_valid,
   input  logic               op_ready,
   output tme_pkg::op_type    op
);
   // two-entry queue between front and back
   tme_pkg::op_type q_ff [2];
   tme_pkg::op_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign pop  = op_valid && op_ready;
   assign op_valid = (cnt_ff != 2'd0);
   assign op = q_ff[rd_ff];

   always_comb begin
      q_in.cmd     = tme_pkg::cmd_type'(req.payload.cmd);
      q_in.known   = (req.payload.cmd inside {tme_pkg::CMD_LOAD, tme_pkg::CMD_INVALIDATE,
                      tme_pkg::CMD_CLEAN, tme_pkg::CMD_FLUSH_ALL, tme_pkg::CMD_FLUSH_ID});
      q_in.page    = req.payload.virt_page;
      q_in.frame   = req.payload.phys_frame;
      q_in.dirty   = req.payload.write_enable;
      q_in.glob    = req.payload.global_flag & asid_mode;
      q_in.id      = asid_mode ? current_asid : '0;
      q_in.target  = req.payload.target_asid;
      q_in.victim  = req.payload.victim_slot;
      q_in.all_ids = asid_mode;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
      end
      if (push) q_ff[wr_ff] <= q_in;
   end
endmodule

[rtl/core/tme_back.sv]
module tme_back #(
   parameter int TABLE_ENTRIES = tme_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   output logic            op_ready,
   input  tme_pkg::op_type op,
   tme_rsp_if.source       rsp
);
   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = IW + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   logic [tme_pkg::PAGE_W-1:0]  page_mem  [TABLE_ENTRIES];
   logic [tme_pkg::ASID_W-1:0]  asid_mem  [TABLE_ENTRIES];
   logic [tme_pkg::FRAME_W-1:0] frame_mem [TABLE_ENTRIES];
   logic                        valid_ff [TABLE_ENTRIES];
   logic                        dirty_ff [TABLE_ENTRIES];
   logic                        glob_ff  [TABLE_ENTRIES];
   logic                        inuse_ff [TABLE_ENTRIES];

   state_type state_ff, state_in;
   tme_pkg::op_type op_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [IW-1:0] idx;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          found_ff, found_in;
   logic [IW-1:0] hslot_ff, hslot_in;
   tme_pkg::rsp_type out_ff;
   logic          out_v_ff, out_v_in;

   // registered read of the entry under test
   logic                        ev_ff;
   logic [IW-1:0]               eidx_ff;
   logic [tme_pkg::PAGE_W-1:0]  rd_page_ff;
   logic [tme_pkg::ASID_W-1:0]  rd_asid_ff;
   logic [tme_pkg::FRAME_W-1:0] rd_frame_ff;
   logic                        rd_glob_ff;
   logic                        rd_inuse_ff;

   logic pmatch, fmatch, imatch, eu, last, issue, fire, clr;
   logic [IW-1:0] wslot;
   logic [tme_pkg::COUNT_W-1:0] sat;

   // victim slot modulo the table size by compare and subtract
   function automatic logic [IW-1:0] wrap_slot(logic [tme_pkg::SLOT_W-1:0] v);
      logic [tme_pkg::SLOT_W-1:0] r;
      r = v;
      for (int k = tme_pkg::SLOT_W - 1; k >= 0; k--) begin
         if ((TABLE_ENTRIES << k) < (1 << tme_pkg::SLOT_W) &&
             r >= tme_pkg::SLOT_W'(TABLE_ENTRIES << k))
            r = r - tme_pkg::SLOT_W'(TABLE_ENTRIES << k);
      end
      return IW'(r);
   endfunction

   assign idx    = idx_ff[IW-1:0];
   assign issue  = (state_ff == ST_SCAN) && (idx_ff != CW'(TABLE_ENTRIES));
   assign last   = (idx_ff == CW'(TABLE_ENTRIES));
   assign eu     = ev_ff && rd_inuse_ff;
   assign pmatch = eu && rd_page_ff == op_ff.page &&
                   (rd_glob_ff || rd_asid_ff == op_ff.id);
   assign fmatch = eu && rd_page_ff == op_ff.page && rd_frame_ff == op_ff.frame;
   assign imatch = eu && rd_asid_ff == op_ff.target;
   assign clr    = (op_ff.all_ids && fmatch) ||
                   (!op_ff.all_ids && pmatch && !found_ff && rd_frame_ff == op_ff.frame);
   assign wslot  = found_ff ? hslot_ff : wrap_slot(op_ff.victim);
   assign sat    = (CW > tme_pkg::COUNT_W && cnt_ff > CW'(127)) ? 7'd127
                                                               : tme_pkg::COUNT_W'(cnt_ff);
   assign fire   = (state_ff == ST_DONE) && (!out_v_ff || rsp.ready);

   assign op_ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      found_in = found_ff;
      hslot_in = hslot_ff;
      out_v_in = out_v_ff;
      if (rsp.ready) out_v_in = 1'b0;
      if (fire) out_v_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               idx_in = '0;
               cnt_in = '0;
               found_in = 1'b0;
               hslot_in = '0;
               state_in = op.known ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            case (op_ff.cmd)
               tme_pkg::CMD_LOAD: begin
                  if (pmatch && !found_ff) begin
                     found_in = 1'b1;
                     hslot_in = eidx_ff;
                  end
               end
               tme_pkg::CMD_INVALIDATE, tme_pkg::CMD_CLEAN: begin
                  if (op_ff.all_ids) begin
                     if (fmatch) cnt_in = cnt_ff + 1'b1;
                  end else if (pmatch && !found_ff) begin
                     found_in = 1'b1;
                     if (rd_frame_ff == op_ff.frame) cnt_in = cnt_ff + 1'b1;
                  end
               end
               tme_pkg::CMD_FLUSH_ALL: if (eu) cnt_in = cnt_ff + 1'b1;
               tme_pkg::CMD_FLUSH_ID:  if (imatch) cnt_in = cnt_ff + 1'b1;
               default: ;
            endcase
            if (issue) idx_in = idx_ff + 1'b1;
            if (last) state_in = (op_ff.cmd == tme_pkg::CMD_LOAD) ? ST_WRITE : ST_DONE;
         end
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  if (fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         ev_ff    <= 1'b0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            dirty_ff[i] <= 1'b0;
            glob_ff[i]  <= 1'b0;
            inuse_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         ev_ff    <= issue;
         if (fire) begin
            out_ff.hit <= op_ff.cmd == tme_pkg::CMD_LOAD && op_ff.known && found_ff;
            out_ff.slot_used <= (op_ff.cmd == tme_pkg::CMD_LOAD && op_ff.known)
                                ? tme_pkg::SLOT_W'(wslot) : '0;
            out_ff.match_count <= (op_ff.cmd == tme_pkg::CMD_LOAD || !op_ff.known)
                                  ? '0 : sat;
         end
         if (state_ff == ST_SCAN) begin
            case (op_ff.cmd)
               tme_pkg::CMD_INVALIDATE, tme_pkg::CMD_CLEAN: begin
                  if (clr) begin
                     if (op_ff.cmd == tme_pkg::CMD_INVALIDATE) valid_ff[eidx_ff] <= 1'b0;
                     else dirty_ff[eidx_ff] <= 1'b0;
                  end
               end
               tme_pkg::CMD_FLUSH_ALL, tme_pkg::CMD_FLUSH_ID: begin
                  if (ev_ff && (op_ff.cmd == tme_pkg::CMD_FLUSH_ALL || imatch)) begin
                     valid_ff[eidx_ff] <= 1'b0;
                     dirty_ff[eidx_ff] <= 1'b0;
                     glob_ff[eidx_ff]  <= 1'b0;
                     inuse_ff[eidx_ff] <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == ST_WRITE) begin
            valid_ff[wslot] <= 1'b1;
            dirty_ff[wslot] <= op_ff.dirty;
            glob_ff[wslot]  <= op_ff.glob;
            inuse_ff[wslot] <= 1'b1;
         end
      end
      if (issue) begin
         rd_page_ff  <= page_mem[idx];
         rd_asid_ff  <= asid_mem[idx];
         rd_frame_ff <= frame_mem[idx];
         rd_glob_ff  <= glob_ff[idx];
         rd_inuse_ff <= inuse_ff[idx];
      end
      eidx_ff <= idx;
      if (state_ff == ST_SCAN && ev_ff && (op_ff.cmd == tme_pkg::CMD_FLUSH_ALL ||
          (op_ff.cmd == tme_pkg::CMD_FLUSH_ID && imatch))) begin
         page_mem[eidx_ff]  <= '0;
         asid_mem[eidx_ff]  <= '0;
         frame_mem[eidx_ff] <= '0;
      end
      if (state_ff == ST_WRITE) begin
         page_mem[wslot]  <= op_ff.page;
         asid_mem[wslot]  <= op_ff.id;
         frame_mem[wslot] <= op_ff.frame;
      end
      if (state_ff == ST_IDLE && op_valid) op_ff <= op;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      found_ff <= found_in;
      hslot_ff <= hslot_in;
   end
endmodule

[rtl/core/tlb_maintenance_engine_core.sv]
// a load scans every table entry, writes its slot, then answers; other commands only
// scan and answer; the back takes a new request only once its response is registered,
// and the scan reads one entry per cycle with its registered table read
// unknown commands skip the scan and go straight to the answer
// reset: synchronous; clears all entry marks at once, asid_mode to 1, current_asid to 0
module tlb_maintenance_engine_core #(
   parameter int TABLE_ENTRIES = tme_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tme_req_if.sink   req,
   tme_rsp_if.source rsp,
   input  logic                              csr_write_enable,
   input  logic [tme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tme_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   logic asid_mode_ff;
   logic [tme_pkg::ASID_W-1:0] current_asid_ff;
   logic op_valid, op_ready;
   tme_pkg::op_type op;

   always_ff @(posedge clock) begin
      if (reset) begin
         asid_mode_ff    <= 1'b1;
         current_asid_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tme_pkg::CSR_ASID_MODE:    asid_mode_ff <= csr_write_data[0];
            tme_pkg::CSR_CURRENT_ASID: current_asid_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   tme_front u_front (
      .clock, .reset, .req,
      .asid_mode(asid_mode_ff), .current_asid(current_asid_ff),
      .op_valid, .op_ready, .op
   );

   tme_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .op_valid, .op_ready, .op, .rsp
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("response dropped while stalled");
   a_hit_load: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.hit |-> rsp.payload.match_count == '0)
      else $error("hit with nonzero count");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      op_valid && op_ready |=> !op_ready)
      else $error("back took two ops");
endmodule
